### sv/swerve_steer_flip_ramp_unit_defines.svh
// Assertion macros shared by the swerve steer flip ramp RTL
`ifndef SWERVE_STEER_FLIP_RAMP_UNIT_DEFINES_SVH
`define SWERVE_STEER_FLIP_RAMP_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Check a consequence in the same cycle as its antecedent
`define SSFR_ASSERT_SAME(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ssfr assertion failed");

// Check a consequence in the cycle after its antecedent
`define SSFR_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ssfr assertion failed");

`else

`define SSFR_ASSERT_SAME(lbl, ck, rstn, ante, cons)
`define SSFR_ASSERT_NEXT(lbl, ck, rstn, ante, cons)

`endif

`endif

### sv/ssfr_pkg.sv
// Package with shared types and constants of the swerve steer flip ramp unit
`timescale 1ns / 1ps

package ssfr_pkg;

  // Q1.15 speed format
  localparam int Q15_W = 16;
  localparam logic signed [Q15_W-1:0] Q15_MAX = 16'sh7FFF;
  localparam logic signed [Q15_W-1:0] Q15_MIN = 16'sh8000;

  // Configuration port geometry
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Register field widths
  localparam int MOUNT_OFFSET_W = 12;
  localparam int DEADBAND_W     = 15;
  localparam int STEP_W         = 15;
  localparam int GAP_W          = 16;

  // Register reset values
  localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 15'd3277;
  localparam logic [STEP_W-1:0]     STEP_RST     = 15'd1311;
  localparam logic [GAP_W-1:0]      GAP_RST      = 16'd32768;

  // Register index, taken from the word address
  typedef enum logic [1:0] {
    REG_MOUNT_OFFSET   = 2'd0,
    REG_SPEED_DEADBAND = 2'd1,
    REG_RAMP_STEP      = 2'd2,
    REG_RAMP_RESET_GAP = 2'd3
  } ssfr_reg_t;

endpackage

### sv/ssfr_ifs.sv
// Valid/ready channel interfaces for command transactions and result transactions
`timescale 1ns / 1ps

interface ssfr_in_if #(
  parameter int ANGLE_BITS = 12
);
  logic                                valid;
  logic                                ready;
  logic signed [ssfr_pkg::Q15_W-1:0]   speed_command;
  logic        [ANGLE_BITS-1:0]        target_angle;
  logic        [ANGLE_BITS-1:0]        encoder_sample;

  modport source (output valid, output speed_command, output target_angle,
                  output encoder_sample, input ready);
  modport sink   (input valid, input speed_command, input target_angle,
                  input encoder_sample, output ready);
endinterface

interface ssfr_out_if #(
  parameter int ANGLE_BITS = 12
);
  logic                                valid;
  logic                                ready;
  logic signed [ssfr_pkg::Q15_W-1:0]   drive_speed;
  logic        [ANGLE_BITS-1:0]        steer_target;
  logic                                reversed;
  logic signed [ANGLE_BITS:0]          angle_error;
  logic        [ANGLE_BITS-1:0]        current_angle;

  modport source (output valid, output drive_speed, output steer_target,
                  output reversed, output angle_error, output current_angle,
                  input ready);
  modport sink   (input valid, input drive_speed, input steer_target,
                  input reversed, input angle_error, input current_angle,
                  output ready);
endinterface

### sv/swerve_steer_flip_ramp_unit.sv
// An accepted command transaction passes through the input register and then the result register.
// Throughput: one transaction per cycle while results are taken; an input register and a result register
// bracket a single pass of adds and compares, and the ramp register feeds back through that pass.
// Reset (synchronous, rst_n low): pipeline emptied, ramped speed cleared to zero and
// configuration registers loaded with their reset values.
`timescale 1ns / 1ps
`include "swerve_steer_flip_ramp_unit_defines.svh"

module swerve_steer_flip_ramp_unit #(
  parameter int ANGLE_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ssfr_in_if.sink                         in_chan,
  ssfr_out_if.source                      out_chan,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [ssfr_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [ssfr_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [ssfr_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  localparam int OFF_BITS = (ANGLE_BITS < ssfr_pkg::MOUNT_OFFSET_W) ?
                            ANGLE_BITS : ssfr_pkg::MOUNT_OFFSET_W;
  localparam int QW = ssfr_pkg::Q15_W;
  // Quarter and three-quarter turn, in the error width
  localparam logic [ANGLE_BITS:0] QUARTER = {2'b00, 1'b1, {(ANGLE_BITS-2){1'b0}}};
  localparam logic [ANGLE_BITS:0] THREE_Q = {2'b01, 1'b1, {(ANGLE_BITS-2){1'b0}}};
  localparam logic signed [ANGLE_BITS:0] QUARTER_S = $signed(QUARTER);
  localparam logic signed [ANGLE_BITS:0] THREE_Q_S = $signed(THREE_Q);

  // Saturate a 17-bit signed value to Q1.15
  function automatic logic signed [QW-1:0] sat_q15(input logic signed [QW:0] v);
    logic signed [QW-1:0] r;
    if (v[QW] != v[QW-1]) begin
      r = v[QW] ? ssfr_pkg::Q15_MIN : ssfr_pkg::Q15_MAX;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic [OFF_BITS-1:0]               off_r;
  logic [ssfr_pkg::DEADBAND_W-1:0]   dead_r;
  logic [ssfr_pkg::STEP_W-1:0]       step_r;
  logic [ssfr_pkg::GAP_W-1:0]        gap_r;
  logic                              cfg_wr;
  ssfr_pkg::ssfr_reg_t               cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_sel    = ssfr_pkg::ssfr_reg_t'(cfg_paddr[3:2]);

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= '0;
      dead_r <= ssfr_pkg::DEADBAND_RST;
      step_r <= ssfr_pkg::STEP_RST;
      gap_r  <= ssfr_pkg::GAP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        ssfr_pkg::REG_MOUNT_OFFSET:   off_r  <= cfg_pwdata[OFF_BITS-1:0];
        ssfr_pkg::REG_SPEED_DEADBAND: dead_r <= cfg_pwdata[ssfr_pkg::DEADBAND_W-1:0];
        ssfr_pkg::REG_RAMP_STEP:      step_r <= cfg_pwdata[ssfr_pkg::STEP_W-1:0];
        ssfr_pkg::REG_RAMP_RESET_GAP: gap_r  <= cfg_pwdata[ssfr_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (cfg_sel)
      ssfr_pkg::REG_MOUNT_OFFSET:   cfg_prdata = ssfr_pkg::CFG_DATA_W'(off_r);
      ssfr_pkg::REG_SPEED_DEADBAND: cfg_prdata = ssfr_pkg::CFG_DATA_W'(dead_r);
      ssfr_pkg::REG_RAMP_STEP:      cfg_prdata = ssfr_pkg::CFG_DATA_W'(step_r);
      ssfr_pkg::REG_RAMP_RESET_GAP: cfg_prdata = ssfr_pkg::CFG_DATA_W'(gap_r);
      default:                      cfg_prdata = '0;
    endcase
  end

  // Handshake: the input stage advances whenever the result register can take a value
  logic a_valid_r;
  logic out_valid_r;
  logic adv;
  logic in_fire;

  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !a_valid_r || adv;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // Input register
  logic signed [QW-1:0]         a_speed_r;
  logic        [ANGLE_BITS-1:0] a_target_r;
  logic        [ANGLE_BITS-1:0] a_enc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      a_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_speed_r  <= in_chan.speed_command;
      a_target_r <= in_chan.target_angle;
      a_enc_r    <= in_chan.encoder_sample;
    end
  end

  // Deadband on the speed command
  logic        [QW:0]           cmd_mag;
  logic signed [QW-1:0]         spd_db;
  assign cmd_mag = a_speed_r[QW-1] ? ((QW+1)'(0) - {1'b1, a_speed_r}) : {1'b0, a_speed_r};
  assign spd_db  = (cmd_mag <= {2'b00, dead_r}) ? '0 : a_speed_r;

  // Current wheel angle and error against the target
  logic        [ANGLE_BITS-1:0] off_ext;
  logic        [ANGLE_BITS-1:0] cur_nxt;
  logic signed [ANGLE_BITS:0]   err_nxt;
  logic        [ANGLE_BITS:0]   err_mag;
  logic                         flip;
  assign off_ext = ANGLE_BITS'(off_r);
  assign cur_nxt = a_enc_r - off_ext;
  assign err_nxt = $signed({1'b0, a_target_r}) - $signed({1'b0, cur_nxt});
  assign err_mag = err_nxt[ANGLE_BITS] ? ((ANGLE_BITS+1)'(0) - err_nxt) : err_nxt;
  assign flip    = (err_mag > QUARTER) && (err_mag < THREE_Q);

  // Turn the target half a turn and negate speed on a flip
  logic        [ANGLE_BITS-1:0] tgt_f;
  logic signed [QW-1:0]         spd_neg;
  logic signed [QW-1:0]         spd_f;
  logic        [ANGLE_BITS-1:0] steer_nxt;
  assign tgt_f     = flip ? {~a_target_r[ANGLE_BITS-1], a_target_r[ANGLE_BITS-2:0]}
                          : a_target_r;
  assign spd_neg   = (spd_db == ssfr_pkg::Q15_MIN) ? ssfr_pkg::Q15_MAX : -spd_db;
  assign spd_f     = flip ? spd_neg : spd_db;
  assign steer_nxt = tgt_f + off_ext;

  // Ramp toward the speed, or drop to zero
  logic signed [QW-1:0] ramp_r;
  logic signed [QW-1:0] ramp_nxt;
  logic signed [QW:0]   gap_diff;
  logic        [QW:0]   gap_mag;
  logic signed [QW:0]   ramp_dn;
  logic signed [QW:0]   ramp_up;
  assign gap_diff = {spd_f[QW-1], spd_f} - {ramp_r[QW-1], ramp_r};
  assign gap_mag  = gap_diff[QW] ? ((QW+1)'(0) - gap_diff) : gap_diff;
  assign ramp_dn  = {ramp_r[QW-1], ramp_r} - $signed({2'b00, step_r});
  assign ramp_up  = {ramp_r[QW-1], ramp_r} + $signed({2'b00, step_r});

  always_comb begin
    if ((spd_f == '0) || (gap_mag > {1'b0, gap_r})) begin
      ramp_nxt = '0;
    end else if (ramp_r > spd_f) begin
      ramp_nxt = sat_q15(ramp_dn);
    end else if (ramp_r < spd_f) begin
      ramp_nxt = sat_q15(ramp_up);
    end else begin
      ramp_nxt = ramp_r;
    end
  end

  // Result register and ramp state
  logic signed [QW-1:0]         drive_r;
  logic        [ANGLE_BITS-1:0] steer_r;
  logic                         rev_r;
  logic signed [ANGLE_BITS:0]   err_r;
  logic        [ANGLE_BITS-1:0] cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ramp_r      <= '0;
    end else if (adv) begin
      out_valid_r <= a_valid_r;
      if (a_valid_r) begin
        ramp_r <= ramp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && a_valid_r) begin
      drive_r <= ramp_nxt;
      steer_r <= steer_nxt;
      rev_r   <= flip;
      err_r   <= err_nxt;
      cur_r   <= cur_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.drive_speed   = drive_r;
  assign out_chan.steer_target  = steer_r;
  assign out_chan.reversed      = rev_r;
  assign out_chan.angle_error   = err_r;
  assign out_chan.current_angle = cur_r;

  // Held result always shows the ramp state it left behind
  `SSFR_ASSERT_SAME(a_drive_is_ramp, clk, rst_n, out_valid_r, drive_r == ramp_r)
  // A stalled result with a waiting item blocks new transactions
  `SSFR_ASSERT_SAME(a_stall_blocks, clk, rst_n, a_valid_r && out_valid_r && !out_chan.ready, !in_chan.ready)
  // An accepted transaction sits in the input register next cycle
  `SSFR_ASSERT_NEXT(a_accept_loads, clk, rst_n, in_fire, a_valid_r)
  // A flip only comes with an error between a quarter and three quarters of a turn
  `SSFR_ASSERT_SAME(a_flip_range, clk, rst_n, out_valid_r && rev_r, (err_r > QUARTER_S && err_r < THREE_Q_S) || (err_r < -QUARTER_S && err_r > -THREE_Q_S))

endmodule

### dv/tb.sv
// Self-checking testbench for the swerve steer flip ramp unit
`timescale 1ns / 1ps

module tb;

  localparam int ANGLE_BITS    = 12;
  localparam int QW            = ssfr_pkg::Q15_W;
  localparam int TURN          = 1 << ANGLE_BITS;
  localparam int ANGLE_MASK    = TURN - 1;
  localparam int CLK_HALF      = 6;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int MAX_GAP       = 19;
  localparam int PHASE_HALF    = 60;

  // One result transaction as the block should produce it
  typedef struct {
    logic signed [QW-1:0]         drive_speed;
    logic        [ANGLE_BITS-1:0] steer_target;
    logic                         reversed;
    logic signed [ANGLE_BITS:0]   angle_error;
    logic        [ANGLE_BITS-1:0] current_angle;
  } wheel_cmd_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [ssfr_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [ssfr_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [ssfr_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  // Shadow copy of the configuration and the ramp register
  int model_offset;
  int model_deadband;
  int model_step;
  int model_gap;
  int model_ramp;

  wheel_cmd_t expected_results[$];
  int         mismatches  = 0;
  int         cycle_count = 0;
  int         send_max_gap = MAX_GAP;
  int         recv_max_gap = MAX_GAP;

  ssfr_in_if  #(.ANGLE_BITS(ANGLE_BITS)) cmd_chan ();
  ssfr_out_if #(.ANGLE_BITS(ANGLE_BITS)) res_chan ();

  swerve_steer_flip_ramp_unit #(.ANGLE_BITS(ANGLE_BITS)) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (cmd_chan),
    .out_chan    (res_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding", $time,
               expected_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int sat_q15(int v);
    if (v > int'(ssfr_pkg::Q15_MAX)) return int'(ssfr_pkg::Q15_MAX);
    if (v < int'(ssfr_pkg::Q15_MIN)) return int'(ssfr_pkg::Q15_MIN);
    return v;
  endfunction

  // Deadband, offset removal, half-turn flip and ramp step for one command
  function automatic wheel_cmd_t steer_and_ramp(logic signed [QW-1:0] speed_cmd,
                                                logic [ANGLE_BITS-1:0] tgt,
                                                logic [ANGLE_BITS-1:0] enc);
    int         speed;
    int         target;
    int         current;
    int         delta;
    int         mag;
    int         next_ramp;
    bit         flip;
    wheel_cmd_t r;
    speed  = int'(speed_cmd);
    target = int'(tgt);
    mag    = (speed < 0) ? -speed : speed;
    if (mag <= model_deadband) speed = 0;

    current = (int'(enc) - model_offset + TURN) & ANGLE_MASK;
    delta   = target - current;
    mag     = (delta < 0) ? -delta : delta;
    flip    = (mag > TURN / 4) && (mag < (3 * TURN) / 4);
    if (flip) begin
      target = (target + TURN / 2) & ANGLE_MASK;
      speed  = sat_q15(-speed);
    end

    // Zero on a stop or a large jump, otherwise step toward the command
    mag = speed - model_ramp;
    if (mag < 0) mag = -mag;
    next_ramp = model_ramp;
    if (speed == 0 || mag > model_gap) begin
      next_ramp = 0;
    end else if (model_ramp > speed) begin
      next_ramp = sat_q15(model_ramp - model_step);
    end else if (model_ramp < speed) begin
      next_ramp = sat_q15(model_ramp + model_step);
    end

    r.drive_speed   = QW'(next_ramp);
    r.steer_target  = ANGLE_BITS'(target + model_offset);
    r.reversed      = flip;
    r.angle_error   = (ANGLE_BITS + 1)'(delta);
    r.current_angle = ANGLE_BITS'(current);
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each accepted result transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    wheel_cmd_t want;
    if (rst_n === 1'b1 && res_chan.valid === 1'b1 && res_chan.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: result transaction with no command outstanding", $time);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("drive_speed", 32'(want.drive_speed), 32'(res_chan.drive_speed));
        check_field("steer_target", 32'(want.steer_target), 32'(res_chan.steer_target));
        check_field("reversed", 32'(want.reversed), 32'(res_chan.reversed));
        check_field("angle_error", 32'(want.angle_error), 32'(res_chan.angle_error));
        check_field("current_angle", 32'(want.current_angle),
                    32'(res_chan.current_angle));
      end
    end
  end

  // Result side: stall a random number of cycles before each transaction
  initial begin : result_sink
    int stall;
    res_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = $urandom_range(0, recv_max_gap);
      if (stall > 0) begin
        res_chan.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_chan.ready <= 1'b1;
      do @(posedge clk); while (res_chan.valid !== 1'b1);
      @(negedge clk);
    end
  end

  // Offer one command transaction, predict its result once accepted
  task automatic send_command(int speed, int tgt, int enc);
    int                       gap;
    wheel_cmd_t               want;
    logic signed [QW-1:0]     spd_bits;
    logic [ANGLE_BITS-1:0]    tgt_bits;
    logic [ANGLE_BITS-1:0]    enc_bits;
    spd_bits = QW'(speed);
    tgt_bits = ANGLE_BITS'(tgt);
    enc_bits = ANGLE_BITS'(enc);
    gap = $urandom_range(0, send_max_gap);
    if (gap > 0) begin
      cmd_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_chan.valid          <= 1'b1;
    cmd_chan.speed_command  <= spd_bits;
    cmd_chan.target_angle   <= tgt_bits;
    cmd_chan.encoder_sample <= enc_bits;
    do @(posedge clk); while (cmd_chan.ready !== 1'b1);
    want       = steer_and_ramp(spd_bits, tgt_bits, enc_bits);
    model_ramp = int'(want.drive_speed);
    expected_results.push_back(want);
    @(negedge clk);
  endtask

  // Drop valid and hold until every outstanding result has arrived
  task automatic wait_idle();
    cmd_chan.valid <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Read one register and compare it with the shadow copy
  task automatic check_register(ssfr_pkg::ssfr_reg_t idx);
    logic [ssfr_pkg::CFG_DATA_W-1:0] want;
    case (idx)
      ssfr_pkg::REG_MOUNT_OFFSET:   want = model_offset;
      ssfr_pkg::REG_SPEED_DEADBAND: want = model_deadband;
      ssfr_pkg::REG_RAMP_STEP:      want = model_step;
      default:                      want = model_gap;
    endcase
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata !== want) begin
      $display("%0t ns: %s read mismatch, expected %0d, actual %0d", $time, idx.name(),
               want, cfg_prdata);
      mismatches++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // Write one register, mask it into the shadow copy and read it back
  task automatic program_register(ssfr_pkg::ssfr_reg_t idx,
                                  logic [ssfr_pkg::CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    case (idx)
      ssfr_pkg::REG_MOUNT_OFFSET:
        model_offset = int'(value[ssfr_pkg::MOUNT_OFFSET_W-1:0]) & ANGLE_MASK;
      ssfr_pkg::REG_SPEED_DEADBAND:
        model_deadband = int'(value[ssfr_pkg::DEADBAND_W-1:0]);
      ssfr_pkg::REG_RAMP_STEP:
        model_step = int'(value[ssfr_pkg::STEP_W-1:0]);
      default:
        model_gap = int'(value[ssfr_pkg::GAP_W-1:0]);
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    check_register(idx);
  endtask

  task automatic apply_setting(logic [ssfr_pkg::CFG_DATA_W-1:0] offset,
                               logic [ssfr_pkg::CFG_DATA_W-1:0] deadband,
                               logic [ssfr_pkg::CFG_DATA_W-1:0] step,
                               logic [ssfr_pkg::CFG_DATA_W-1:0] gap);
    wait_idle();
    program_register(ssfr_pkg::REG_MOUNT_OFFSET, offset);
    program_register(ssfr_pkg::REG_SPEED_DEADBAND, deadband);
    program_register(ssfr_pkg::REG_RAMP_STEP, step);
    program_register(ssfr_pkg::REG_RAMP_RESET_GAP, gap);
  endtask

  // Registers must come out of reset at their documented values
  task automatic test_reset_values();
    ssfr_pkg::ssfr_reg_t reg_idx;
    reg_idx = reg_idx.first();
    repeat (reg_idx.num()) begin
      check_register(reg_idx);
      reg_idx = reg_idx.next();
    end
  endtask

  // Deadband edges, strict flip bounds and saturating negation
  task automatic test_deadband_and_flip();
    send_command(model_deadband, 0, 0);
    send_command(model_deadband + 1, 0, 0);
    send_command(-model_deadband, 0, 0);
    send_command(-model_deadband - 1, 0, 0);
    send_command(int'(ssfr_pkg::Q15_MAX), ANGLE_MASK, 0);
    send_command(int'(ssfr_pkg::Q15_MIN), 0, ANGLE_MASK);
    send_command(20000, TURN / 4, 0);
    send_command(20000, TURN / 4 + 1, 0);
    send_command(20000, 3 * TURN / 4, 0);
    send_command(20000, 3 * TURN / 4 - 1, 0);
    send_command(20000, 0, TURN / 4);
    send_command(20000, 0, TURN / 4 + 1);
    send_command(20000, 0, 3 * TURN / 4);
    send_command(20000, 0, 3 * TURN / 4 - 1);
    // full-scale negative command flipped: negation saturates
    send_command(int'(ssfr_pkg::Q15_MIN), TURN / 2, 0);
    send_command(int'(ssfr_pkg::Q15_MIN), TURN / 2, 0);
    send_command(int'(ssfr_pkg::Q15_MAX), ANGLE_MASK, ANGLE_MASK);
  endtask

  // Offset wrap, gap edge, equal hold, zero step and ramp saturation
  task automatic test_ramp_cases();
    apply_setting(ANGLE_MASK, 0, 1311, 1000);
    send_command(0, 0, 0);
    send_command(0, 10, 0);
    send_command(1000, 0, 0);
    send_command(1311, 0, 0);
    send_command(2312, 0, 0);
    apply_setting(ANGLE_MASK, 0, 0, 65535);
    send_command(500, 0, 0);
    send_command(-500, 0, 0);
    apply_setting(0, 0, 20000, 65535);
    send_command(int'(ssfr_pkg::Q15_MAX), 0, 0);
    send_command(int'(ssfr_pkg::Q15_MAX), 0, 0);
    repeat (4) send_command(int'(ssfr_pkg::Q15_MIN), 0, 0);
  endtask

  // Runs of one speed over consistent flip geometry, mixed with noise
  task automatic run_random_items(int count);
    int sent;
    int run_len;
    int cur;
    int err;
    bit seq_flip;
    int cmd;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 3) == 0) begin
        send_command($urandom, $urandom, $urandom);
        sent++;
      end else begin
        case ($urandom_range(0, 7))
          0:       cmd = int'(ssfr_pkg::Q15_MAX);
          1:       cmd = int'(ssfr_pkg::Q15_MIN);
          2:       cmd = model_deadband + $urandom_range(0, 1);
          3:       cmd = -model_deadband - $urandom_range(0, 1);
          default: cmd = $urandom;
        endcase
        run_len  = $urandom_range(1, 12);
        seq_flip = 1'($urandom_range(0, 1));
        repeat (run_len) begin
          cur = $urandom_range(0, ANGLE_MASK);
          if (seq_flip) err = $urandom_range(TURN / 4 + 1, 3 * TURN / 4 - 1);
          else err = $urandom_range(0, TURN / 4);
          if ($urandom_range(0, 1)) err = -err;
          send_command(cmd, cur + err, cur + model_offset);
          sent++;
        end
      end
    end
  endtask

  // One phase: half the traffic, a full drain, then the rest with swapped idling
  task automatic run_phase(int first_send_gap, int first_recv_gap);
    send_max_gap = first_send_gap;
    recv_max_gap = first_recv_gap;
    run_random_items(PHASE_HALF);
    wait_idle();
    send_max_gap = first_recv_gap;
    recv_max_gap = first_send_gap;
    run_random_items(PHASE_HALF);
  endtask

  task automatic test_random_traffic();
    // all ones: every register masked to its maximum
    apply_setting('1, '1, '1, '1);
    run_phase(MAX_GAP, MAX_GAP);
    apply_setting(0, 0, 1, 0);
    run_phase(0, 0);
    apply_setting(TURN / 2, 32'(ssfr_pkg::DEADBAND_RST), 32'(ssfr_pkg::STEP_RST),
                  32'(ssfr_pkg::GAP_RST));
    run_phase(0, MAX_GAP);
    apply_setting($urandom, $urandom_range(0, 6000), $urandom_range(1, 8000),
                  $urandom_range(0, 65535));
    run_phase(MAX_GAP, 0);
    apply_setting($urandom, 100, 3000, 40000);
    run_phase(MAX_GAP, MAX_GAP);
  endtask

  initial begin
    rst_n                   = 1'b0;
    cmd_chan.valid          = 1'b0;
    cmd_chan.speed_command  = '0;
    cmd_chan.target_angle   = '0;
    cmd_chan.encoder_sample = '0;
    cfg_psel                = 1'b0;
    cfg_penable             = 1'b0;
    cfg_pwrite              = 1'b0;
    cfg_paddr               = '0;
    cfg_pwdata              = '0;
    model_offset            = 0;
    model_deadband          = int'(ssfr_pkg::DEADBAND_RST);
    model_step              = int'(ssfr_pkg::STEP_RST);
    model_gap               = int'(ssfr_pkg::GAP_RST);
    model_ramp              = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_deadband_and_flip();
    test_ramp_cases();
    test_random_traffic();

    wait_idle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
